### rtl/lrpc_pkg.sv
`default_nettype none

package lrpc_pkg;

  localparam int TABLE_ROWS_DEF = 256;
  localparam int ROWS_W         = 9;
  localparam int ROW_IDX_W      = 8;
  localparam int KEY_W          = 8;
  localparam int COMP_W         = 8;
  localparam int BOUND_W        = 10;
  // priority encode runs over groups of PRIO_GRP match bits
  localparam int PRIO_GRP       = 16;
  localparam int PRIO_LOC_W     = 4;

  typedef logic signed [BOUND_W-1:0] bound_t;

  localparam bound_t BOUND_MIN = -10'sd1;
  localparam bound_t BOUND_MAX = 10'sd256;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } stage_ctl_t;

  typedef struct packed {
    bound_t first_low;
    bound_t first_high;
    bound_t second_low;
    bound_t second_high;
  } bounds_t;

  // payload that rides down the pipe alongside the match result
  typedef struct packed {
    logic                  row_ok;
    logic [ROW_IDX_W-1:0]  row_index;
    bounds_t               bounds;
    logic [COMP_W-1:0]     first_comp;
    logic [COMP_W-1:0]     second_comp;
  } carry_t;

  function automatic bound_t clamp_bound(input bound_t b);
    bound_t res;
    res = b;
    if (b < BOUND_MIN) begin
      res = BOUND_MIN;
    end else if (b > BOUND_MAX) begin
      res = BOUND_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/lrpc_key_match.sv
`default_nettype none

module lrpc_key_match
  import lrpc_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic [ROWS_W-1:0]     rows_in_use,
  input  wire stage_ctl_t            s1_ctl,
  input  wire logic [KEY_W-1:0]      s1_key,
  input  wire logic [KEY_W-1:0]      s1_level,
  input  wire carry_t                s1_carry,
  output stage_ctl_t                 s2_ctl_r,
  output logic [TABLE_ROWS-1:0]      s2_match_r,
  output carry_t                     s2_carry_r
);

  logic [KEY_W-1:0]      key_r [TABLE_ROWS];
  logic [TABLE_ROWS-1:0] match_nxt;
  logic                  wr_en;

  assign wr_en = adv && s1_ctl.valid && (s1_ctl.cmd == CMD_WRITE) && s1_carry.row_ok;

  // one key register and one comparator per table row
  for (genvar i = 0; i < TABLE_ROWS; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (wr_en && (32'(s1_carry.row_index) == 32'(i))) begin
        key_r[i] <= s1_key;
      end
    end

    assign match_nxt[i] = (s1_ctl.cmd == CMD_PIXEL) && (key_r[i] == s1_level) &&
                          (32'(rows_in_use) > 32'(i));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_match_r <= match_nxt;
      s2_carry_r <= s1_carry;
    end
  end

endmodule

`default_nettype wire

### rtl/lrpc_prio_enc.sv
`default_nettype none

module lrpc_prio_enc
  import lrpc_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF,
  parameter int IDX_W      = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire stage_ctl_t            s2_ctl,
  input  wire logic [TABLE_ROWS-1:0] s2_match,
  input  wire carry_t                s2_carry,
  output stage_ctl_t                 s4_ctl_r,
  output logic                       s4_hit_r,
  output logic [IDX_W-1:0]           s4_idx_r,
  output carry_t                     s4_carry_r
);

  localparam int NGRP  = (TABLE_ROWS + PRIO_GRP - 1) / PRIO_GRP;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD   = NGRP * PRIO_GRP;

  logic [PAD-1:0]        match_pad;
  logic [NGRP-1:0]       grp_any_nxt;
  logic [PRIO_LOC_W-1:0] grp_loc_nxt [NGRP];

  stage_ctl_t            s3_ctl_r;
  logic [NGRP-1:0]       s3_any_r;
  logic [PRIO_LOC_W-1:0] s3_loc_r [NGRP];
  carry_t                s3_carry_r;

  logic                  hit_nxt;
  logic [IDX_W-1:0]      idx_nxt;

  assign match_pad = PAD'(s2_match);

  // first level: lowest set bit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |match_pad[g*PRIO_GRP +: PRIO_GRP];
      grp_loc_nxt[g] = '0;
      for (int j = PRIO_GRP - 1; j >= 0; j--) begin
        if (match_pad[g*PRIO_GRP + j]) begin
          grp_loc_nxt[g] = PRIO_LOC_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_any_r   <= grp_any_nxt;
      s3_loc_r   <= grp_loc_nxt;
      s3_carry_r <= s2_carry;
    end
  end

  // second level: lowest group that holds a match
  always_comb begin
    hit_nxt = |s3_any_r;
    idx_nxt = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (s3_any_r[g]) begin
        idx_nxt = IDX_W'({GRP_W'(g), s3_loc_r[g]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (adv) begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hit_r   <= hit_nxt;
      s4_idx_r   <= idx_nxt;
      s4_carry_r <= s3_carry_r;
    end
  end

endmodule

`default_nettype wire

### rtl/lrpc_bound_check.sv
`default_nettype none

module lrpc_bound_check
  import lrpc_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF,
  parameter int IDX_W      = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire stage_ctl_t       s4_ctl,
  input  wire logic             s4_hit,
  input  wire logic [IDX_W-1:0] s4_idx,
  input  wire carry_t           s4_carry,
  output logic                  out_valid,
  output logic                  out_object_flag,
  output logic                  out_key_matched
);

  bounds_t           bound_mem [TABLE_ROWS];
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;

  stage_ctl_t        s5_ctl_r;
  logic              s5_hit_r;
  logic [COMP_W-1:0] s5_c1_r;
  logic [COMP_W-1:0] s5_c2_r;
  bounds_t           s5_bounds_r;

  bound_t            c1_s;
  bound_t            c2_s;
  logic              flag_nxt;
  logic              res_nxt;

  logic              out_valid_r;
  logic              out_flag_r;
  logic              out_matched_r;

  assign wr_addr = IDX_W'(s4_carry.row_index);
  assign wr_en   = adv && s4_ctl.valid && (s4_ctl.cmd == CMD_WRITE) && s4_carry.row_ok;

  // writes and reads share this stage, so table updates stay in item order
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bound_mem[wr_addr] <= s4_carry.bounds;
    end
    if (adv) begin
      s5_bounds_r <= bound_mem[s4_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_ctl_r <= '0;
    end else if (adv) begin
      s5_ctl_r <= s4_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit_r <= s4_hit;
      s5_c1_r  <= s4_carry.first_comp;
      s5_c2_r  <= s4_carry.second_comp;
    end
  end

  assign c1_s = bound_t'({{(BOUND_W-COMP_W){1'b0}}, s5_c1_r});
  assign c2_s = bound_t'({{(BOUND_W-COMP_W){1'b0}}, s5_c2_r});

  assign flag_nxt = s5_hit_r &&
                    (c1_s > s5_bounds_r.first_low)  && (c1_s < s5_bounds_r.first_high) &&
                    (c2_s > s5_bounds_r.second_low) && (c2_s < s5_bounds_r.second_high);

  // only pixel transfers produce a result
  assign res_nxt = s5_ctl_r.valid && (s5_ctl_r.cmd == CMD_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_nxt) begin
      out_flag_r    <= flag_nxt;
      out_matched_r <= s5_hit_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_object_flag = out_flag_r;
  assign out_key_matched = out_matched_r;

endmodule

`default_nettype wire

### rtl/lut_range_pixel_classifier.sv
// A pixel transfer passes the input register and the register stages key compare,
// group priority pick, final pick, bound table read and interval compare, which
// all advance together: one item per cycle unless a result waits at the output.
// Table writes produce no result. Synchronous active-low reset clears the valid
// bits and rows_in_use; the key and bound tables hold nothing defined until written.
`default_nettype none

module lut_range_pixel_classifier
  import lrpc_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [ROWS_W-1:0]    cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_cmd,
  input  wire logic [ROW_IDX_W-1:0] in_row_index,
  input  wire logic [KEY_W-1:0]     in_row_key,
  input  wire bound_t               in_first_low_bound,
  input  wire bound_t               in_first_high_bound,
  input  wire bound_t               in_second_low_bound,
  input  wire bound_t               in_second_high_bound,
  input  wire logic [KEY_W-1:0]     in_pixel_level,
  input  wire logic [COMP_W-1:0]    in_first_component,
  input  wire logic [COMP_W-1:0]    in_second_component,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_object_flag,
  output logic                      out_key_matched
);

  localparam int IDX_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

  logic                  adv;
  logic [ROWS_W-1:0]     rows_in_use_r;

  stage_ctl_t            s1_ctl_r;
  stage_ctl_t            s1_ctl_nxt;
  logic [KEY_W-1:0]      s1_key_r;
  logic [KEY_W-1:0]      s1_level_r;
  carry_t                s1_carry_r;
  carry_t                s1_carry_nxt;

  stage_ctl_t            s2_ctl;
  logic [TABLE_ROWS-1:0] s2_match;
  carry_t                s2_carry;

  stage_ctl_t            s4_ctl;
  logic                  s4_hit;
  logic [IDX_W-1:0]      s4_idx;
  carry_t                s4_carry;

  // whole pipe moves unless a finished result waits at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= '0;
    end else if (cfg_wr_en) begin
      rows_in_use_r <= cfg_wr_data;
    end
  end

  always_comb begin
    s1_ctl_nxt = s1_ctl_r;
    if (adv) begin
      s1_ctl_nxt.valid = in_valid;
      s1_ctl_nxt.cmd   = cmd_t'(in_cmd);
    end
  end

  always_comb begin
    s1_carry_nxt.row_ok             = 32'(in_row_index) < 32'(TABLE_ROWS);
    s1_carry_nxt.row_index          = in_row_index;
    s1_carry_nxt.bounds.first_low   = clamp_bound(in_first_low_bound);
    s1_carry_nxt.bounds.first_high  = clamp_bound(in_first_high_bound);
    s1_carry_nxt.bounds.second_low  = clamp_bound(in_second_low_bound);
    s1_carry_nxt.bounds.second_high = clamp_bound(in_second_high_bound);
    s1_carry_nxt.first_comp         = in_first_component;
    s1_carry_nxt.second_comp        = in_second_component;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_key_r   <= in_row_key;
      s1_level_r <= in_pixel_level;
      s1_carry_r <= s1_carry_nxt;
    end
  end

  lrpc_key_match #(
    .TABLE_ROWS (TABLE_ROWS)
  ) u_key_match (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .rows_in_use (rows_in_use_r),
    .s1_ctl      (s1_ctl_r),
    .s1_key      (s1_key_r),
    .s1_level    (s1_level_r),
    .s1_carry    (s1_carry_r),
    .s2_ctl_r    (s2_ctl),
    .s2_match_r  (s2_match),
    .s2_carry_r  (s2_carry)
  );

  lrpc_prio_enc #(
    .TABLE_ROWS (TABLE_ROWS),
    .IDX_W      (IDX_W)
  ) u_prio_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s2_ctl     (s2_ctl),
    .s2_match   (s2_match),
    .s2_carry   (s2_carry),
    .s4_ctl_r   (s4_ctl),
    .s4_hit_r   (s4_hit),
    .s4_idx_r   (s4_idx),
    .s4_carry_r (s4_carry)
  );

  lrpc_bound_check #(
    .TABLE_ROWS (TABLE_ROWS),
    .IDX_W      (IDX_W)
  ) u_bound_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .s4_ctl          (s4_ctl),
    .s4_hit          (s4_hit),
    .s4_idx          (s4_idx),
    .s4_carry        (s4_carry),
    .out_valid       (out_valid),
    .out_object_flag (out_object_flag),
    .out_key_matched (out_key_matched)
  );

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // an object pixel needs a key match
  a_flag_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_object_flag) |-> out_key_matched)
    else $error("object flag set without key match");

  // a stall holds the first stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (s1_ctl_r == $past(s1_ctl_r)))
    else $error("first stage changed during stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

### sim/lut_range_pixel_classifier_tb.sv
module lut_range_pixel_classifier_tb;
  import lrpc_pkg::*;

  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_ROWS       = TABLE_ROWS_DEF;

  typedef struct packed {
    cmd_t                  cmd;
    logic [ROW_IDX_W-1:0]  row;
    logic [KEY_W-1:0]      key;
    bound_t                lo1;
    bound_t                hi1;
    bound_t                lo2;
    bound_t                hi2;
    logic [KEY_W-1:0]      level;
    logic [COMP_W-1:0]     c1;
    logic [COMP_W-1:0]     c2;
  } lut_item_t;

  typedef struct packed {
    logic object_flag;
    logic key_matched;
  } mask_t;

  typedef struct {
    logic              is_cfg;
    logic [ROWS_W-1:0] rows;
    lut_item_t         item;
    logic              fixed;
    mask_t             mask;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [ROWS_W-1:0]    cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_cmd;
  logic [ROW_IDX_W-1:0] in_row_index;
  logic [KEY_W-1:0]     in_row_key;
  bound_t               in_first_low_bound;
  bound_t               in_first_high_bound;
  bound_t               in_second_low_bound;
  bound_t               in_second_high_bound;
  logic [KEY_W-1:0]     in_pixel_level;
  logic [COMP_W-1:0]    in_first_component;
  logic [COMP_W-1:0]    in_second_component;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_object_flag;
  logic                 out_key_matched;

  lut_range_pixel_classifier dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_row_index         (in_row_index),
    .in_row_key           (in_row_key),
    .in_first_low_bound   (in_first_low_bound),
    .in_first_high_bound  (in_first_high_bound),
    .in_second_low_bound  (in_second_low_bound),
    .in_second_high_bound (in_second_high_bound),
    .in_pixel_level       (in_pixel_level),
    .in_first_component   (in_first_component),
    .in_second_component  (in_second_component),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_object_flag      (out_object_flag),
    .out_key_matched      (out_key_matched)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the table and the row count
  logic [KEY_W-1:0]  key_tbl [N_ROWS];
  bounds_t           bnd_tbl [N_ROWS];
  logic [ROWS_W-1:0] rows_in_use;

  mask_t    mask_q [$];
  dir_row_t dir_q  [$];

  int errors;
  int cyc;
  int burst_left;
  bit steady;
  int n_writes;
  int n_pixels;
  int n_matched;
  int n_object;
  int n_cfg;

  function automatic bound_t pin_bound(input bound_t b);
    if (b < BOUND_MIN) return BOUND_MIN;
    if (b > BOUND_MAX) return BOUND_MAX;
    return b;
  endfunction

  function automatic mask_t classify_pixel(input lut_item_t it);
    int    n;
    mask_t r;
    r = '0;
    n = (int'(rows_in_use) > N_ROWS) ? N_ROWS : int'(rows_in_use);
    for (int m = 0; m < n; m++) begin
      if (key_tbl[m] == it.level) begin
        r.key_matched = 1'b1;
        r.object_flag = (int'(it.c1) > int'(bnd_tbl[m].first_low)) &&
                        (int'(it.c1) < int'(bnd_tbl[m].first_high)) &&
                        (int'(it.c2) > int'(bnd_tbl[m].second_low)) &&
                        (int'(it.c2) < int'(bnd_tbl[m].second_high));
        break;
      end
    end
    return r;
  endfunction

  // fields that the command does not use carry random junk
  function automatic lut_item_t junk_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(lut_item_t)-1:0];
  endfunction

  function automatic lut_item_t mk_write(input int row, input int key, input int lo1,
                                         input int hi1, input int lo2, input int hi2);
    lut_item_t it;
    it     = junk_item();
    it.cmd = CMD_WRITE;
    it.row = ROW_IDX_W'(row);
    it.key = KEY_W'(key);
    it.lo1 = bound_t'(lo1);
    it.hi1 = bound_t'(hi1);
    it.lo2 = bound_t'(lo2);
    it.hi2 = bound_t'(hi2);
    return it;
  endfunction

  function automatic lut_item_t mk_pixel(input int level, input int c1, input int c2);
    lut_item_t it;
    it       = junk_item();
    it.cmd   = CMD_PIXEL;
    it.level = KEY_W'(level);
    it.c1    = COMP_W'(c1);
    it.c2    = COMP_W'(c2);
    return it;
  endfunction

  function automatic dir_row_t d_item(input lut_item_t it);
    dir_row_t d;
    d = '{1'b0, '0, it, 1'b0, '0};
    return d;
  endfunction

  function automatic dir_row_t d_fixed(input lut_item_t it, input logic f, input logic m);
    dir_row_t d;
    d = '{1'b0, '0, it, 1'b1, mask_t'({f, m})};
    return d;
  endfunction

  function automatic dir_row_t d_cfg(input int v);
    dir_row_t d;
    d = '{1'b1, ROWS_W'(v), junk_item(), 1'b0, '0};
    return d;
  endfunction

  function automatic int rand_key();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
  endfunction

  // mostly plausible intervals, some raw 10-bit bounds that get clamped
  function automatic int rand_lo();
    return ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 161)) - 1
                                      : int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int rand_hi(input int lo);
    return ($urandom_range(0, 9) < 7) ? lo + int'($urandom_range(1, 200))
                                      : int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic lut_item_t rand_write(input int row);
    int lo1;
    int lo2;
    lo1 = rand_lo();
    lo2 = rand_lo();
    return mk_write(row, rand_key(), lo1, rand_hi(lo1), lo2, rand_hi(lo2));
  endfunction

  function automatic int rand_comp();
    if ($urandom_range(0, 6) == 0) return ($urandom_range(0, 1) != 0) ? 255 : 0;
    return $urandom_range(0, 255);
  endfunction

  function automatic lut_item_t rand_pixel();
    int lvl;
    lvl = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    return mk_pixel(lvl, rand_comp(), rand_comp());
  endfunction

  task automatic push_item(input lut_item_t it, input logic fixed, input mask_t typed_mask);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid             <= 1'b1;
    in_cmd               <= it.cmd;
    in_row_index         <= it.row;
    in_row_key           <= it.key;
    in_first_low_bound   <= it.lo1;
    in_first_high_bound  <= it.hi1;
    in_second_low_bound  <= it.lo2;
    in_second_high_bound <= it.hi2;
    in_pixel_level       <= it.level;
    in_first_component   <= it.c1;
    in_second_component  <= it.c2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    // advance the predictor in transfer order
    if (it.cmd == CMD_WRITE) begin
      key_tbl[it.row] = it.key;
      bnd_tbl[it.row] = '{pin_bound(it.lo1), pin_bound(it.hi1),
                          pin_bound(it.lo2), pin_bound(it.hi2)};
      n_writes++;
    end else begin
      mask_q.push_back(fixed ? typed_mask : classify_pixel(it));
      n_pixels++;
    end
  endtask

  task automatic set_rows_in_use(input logic [ROWS_W-1:0] v);
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (mask_q.size() != 0) @(posedge clk);
    // table writes still in the pipe give no result: let them settle
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rows_in_use = v;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    mask_t got;
    mask_t want;
    cyc++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = mask_t'({out_object_flag, out_key_matched});
        if (mask_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: object_flag %b key_matched %b",
                   $time, got.object_flag, got.key_matched);
        end else begin
          want = mask_q.pop_front();
          n_matched += got.key_matched;
          n_object  += got.object_flag;
          if (got.object_flag !== want.object_flag) begin
            errors++;
            $display("%0t: object_flag expected %b actual %b",
                     $time, want.object_flag, got.object_flag);
          end
          if (got.key_matched !== want.key_matched) begin
            errors++;
            $display("%0t: key_matched expected %b actual %b",
                     $time, want.key_matched, got.key_matched);
          end
        end
      end
      // receiver stall pattern: free running, sparse, periodic, heavy
      case ((cyc / 150) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ((cyc % 7) < 3);
        default: out_ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
    if (cyc == LIMIT) begin
      $display("lut_range_pixel_classifier_tb failed");
      $finish;
    end
  end

  initial begin
    int       cfg_list [9];
    dir_row_t d;
    rst_n                <= 1'b0;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    in_valid             <= 1'b0;
    in_cmd               <= CMD_WRITE;
    in_row_index         <= '0;
    in_row_key           <= '0;
    in_first_low_bound   <= '0;
    in_first_high_bound  <= '0;
    in_second_low_bound  <= '0;
    in_second_high_bound <= '0;
    in_pixel_level       <= '0;
    in_first_component   <= '0;
    in_second_component  <= '0;
    errors      = 0;
    cyc         = 0;
    burst_left  = 0;
    steady      = 1'b0;
    n_writes    = 0;
    n_pixels    = 0;
    n_matched   = 0;
    n_object    = 0;
    n_cfg       = 0;
    rows_in_use = '0;

    // empty search straight after reset
    dir_q.push_back(d_fixed(mk_pixel(0, 0, 0), 1'b0, 1'b0));
    dir_q.push_back(d_fixed(mk_pixel(255, 255, 255), 1'b0, 1'b0));
    // bounds beyond both ends get clamped to -1 and 256
    dir_q.push_back(d_item(mk_write(0, 5, -512, 511, -1, 256)));
    // same key as row 0, so shadowed by it
    dir_q.push_back(d_item(mk_write(1, 5, 100, 101, 100, 101)));
    dir_q.push_back(d_item(mk_write(2, 255, 10, 20, 100, 200)));
    // interval turned inside out by clamping
    dir_q.push_back(d_item(mk_write(3, 0, 300, -300, 0, 0)));
    dir_q.push_back(d_cfg(4));
    dir_q.push_back(d_fixed(mk_pixel(5, 0, 0), 1'b1, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(5, 255, 255), 1'b1, 1'b1));
    // open interval edges
    dir_q.push_back(d_fixed(mk_pixel(255, 10, 150), 1'b0, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(255, 11, 199), 1'b1, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(255, 19, 200), 1'b0, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(255, 20, 150), 1'b0, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(0, 128, 128), 1'b0, 1'b1));
    dir_q.push_back(d_fixed(mk_pixel(7, 128, 128), 1'b0, 1'b0));
    // overwrite then read back at once
    dir_q.push_back(d_item(mk_write(1, 7, 0, 256, -1, 255)));
    dir_q.push_back(d_item(mk_pixel(7, 1, 254)));
    dir_q.push_back(d_item(mk_pixel(7, 0, 100)));
    dir_q.push_back(d_cfg(1));
    // key present only beyond the rows in use
    dir_q.push_back(d_fixed(mk_pixel(255, 15, 150), 1'b0, 1'b0));
    dir_q.push_back(d_fixed(mk_pixel(5, 128, 128), 1'b1, 1'b1));
    dir_q.push_back(d_item(mk_write(0, 255, -1, 256, -1, 256)));
    dir_q.push_back(d_item(mk_pixel(255, 0, 255)));
    dir_q.push_back(d_item(mk_pixel(5, 0, 0)));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_q[i]) begin
      d = dir_q[i];
      if (d.is_cfg) set_rows_in_use(d.rows);
      else push_item(d.item, d.fixed, d.mask);
    end

    // fill the rest of the table so any row count is safe to search
    for (int r = 4; r < N_ROWS; r++) begin
      push_item(rand_write(r), 1'b0, '0);
      if (r % 3 == 0) push_item(rand_pixel(), 1'b0, '0);
    end

    cfg_list = '{256, 0, 511, 2, 257, 32, $urandom_range(0, 511), 1, 128};
    foreach (cfg_list[p]) begin
      set_rows_in_use(ROWS_W'(cfg_list[p]));
      steady = (p % 3 == 1);
      repeat (50) begin
        if ($urandom_range(0, 3) == 0)
          push_item(rand_write(($urandom_range(0, 1) != 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 255)),
                    1'b0, '0);
        else
          push_item(rand_pixel(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (mask_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d row writes, %0d pixels over %0d row-count settings",
             n_writes, n_pixels, n_cfg);
    $display("pixels with a key hit: %0d, object pixels: %0d, mismatches: %0d",
             n_matched, n_object, errors);
    if (errors == 0) $display("lut_range_pixel_classifier_tb passed");
    else $display("lut_range_pixel_classifier_tb failed");
    $finish;
  end

endmodule

### filelist.f
rtl/lrpc_pkg.sv
rtl/lrpc_key_match.sv
rtl/lrpc_prio_enc.sv
rtl/lrpc_bound_check.sv
rtl/lut_range_pixel_classifier.sv
sim/lut_range_pixel_classifier_tb.sv
